// File: rtl/bmd_pkg.sv
// Shared types and constants for the block median downsampler.
package bmd_pkg;

   // Default sizes handed to the top level parameters
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_BLOCK_EDGE = 4;

   // Field and register widths
   localparam int PIX_W = 8;
   localparam int IDX_W = 8;
   localparam int CSR_W = 11;
   localparam int CSR_INDEX_W = 1;

   // Register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [CSR_W-1:0] RESET_IMAGE_WIDTH  = 11'd512;
   localparam logic [CSR_W-1:0] RESET_IMAGE_HEIGHT = 11'd512;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] median_value;
      logic [IDX_W-1:0] block_column;
      logic [IDX_W-1:0] block_row;
      logic             frame_last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SORT,
      ST_DONE
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic fetch_issue;
      logic fetch_capture;
      logic sort_step;
      logic sort_odd;
      logic load_out;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic block_end;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/block_median_downsampler_unit.sv
// Top level of the block median downsampler (4x4 blocks by default).
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_data  (bmd_pkg::req_type)
//   rsp_      out        rsp_valid/rsp_stall   rsp_data  (bmd_pkg::rsp_type)
//   csr_      in         csr_we                csr_index, csr_wdata
//
// A pixel that does not close a block is accepted without a stall. The bottom-right
// pixel of a block is followed by (BLOCK_EDGE-1)*BLOCK_EDGE line store reads (one
// read port), BLOCK_EDGE*BLOCK_EDGE sort passes and one load of the output register
// before the next pixel is taken.
// A full output register that is stalled holds off that load.
// Reset is synchronous; it clears counters and control and sets the sizes to 512 x 512.
// The line store needs no clearing pass after reset.
module block_median_downsampler_unit #(
   parameter int MAX_WIDTH  = bmd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmd_pkg::DEF_MAX_HEIGHT,
   parameter int BLOCK_EDGE = bmd_pkg::DEF_BLOCK_EDGE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bmd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bmd_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [bmd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bmd_pkg::CSR_W-1:0]       csr_wdata
);

   bmd_pkg::ctrl_cmd_type  cmd;
   bmd_pkg::dp_status_type status;

   bmd_controller #(
      .BLOCK_EDGE (BLOCK_EDGE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bmd_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .BLOCK_EDGE (BLOCK_EDGE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/bmd_datapath.sv
// Datapath: position counters, line store, block gather, sorting network, output register.
module bmd_datapath #(
   parameter int MAX_WIDTH  = bmd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmd_pkg::DEF_MAX_HEIGHT,
   parameter int BLOCK_EDGE = bmd_pkg::DEF_BLOCK_EDGE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bmd_pkg::req_type                    req_data,
   input  logic                                csr_we,
   input  logic [bmd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bmd_pkg::CSR_W-1:0]           csr_wdata,
   input  bmd_pkg::ctrl_cmd_type               cmd,
   output bmd_pkg::dp_status_type              status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bmd_pkg::rsp_type                    rsp_data
);

   localparam int NPIX        = BLOCK_EDGE * BLOCK_EDGE;
   localparam int NFETCH      = (BLOCK_EDGE - 1) * BLOCK_EDGE;
   localparam int STORE_DEPTH = (BLOCK_EDGE - 1) * MAX_WIDTH;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int CW          = $clog2(MAX_WIDTH + 1);
   localparam int RW          = $clog2(MAX_HEIGHT + 1);
   localparam int BW          = $clog2(BLOCK_EDGE);
   localparam int LWW         = (CW > bmd_pkg::CSR_W) ? CW : bmd_pkg::CSR_W;
   localparam int LWH         = (RW > bmd_pkg::CSR_W) ? RW : bmd_pkg::CSR_W;
   localparam int PW          = bmd_pkg::PIX_W;
   localparam int IDX_W       = bmd_pkg::IDX_W;
   localparam logic [BW-1:0] EDGE_LAST = BW'(BLOCK_EDGE - 1);

   // Configuration registers
   logic [bmd_pkg::CSR_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bmd_pkg::RESET_IMAGE_WIDTH;
         height_ff <= bmd_pkg::RESET_IMAGE_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            bmd_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            bmd_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sizes in use, saturated to the supported range
   logic [LWW-1:0] w_wide;
   logic [LWH-1:0] h_wide;
   logic [CW-1:0]  w_eff;
   logic [RW-1:0]  h_eff;

   always_comb begin
      w_wide = LWW'(width_ff);
      h_wide = LWH'(height_ff);
      if (w_wide < LWW'(BLOCK_EDGE))     w_wide = LWW'(BLOCK_EDGE);
      else if (w_wide > LWW'(MAX_WIDTH)) w_wide = LWW'(MAX_WIDTH);
      if (h_wide < LWH'(BLOCK_EDGE))      h_wide = LWH'(BLOCK_EDGE);
      else if (h_wide > LWH'(MAX_HEIGHT)) h_wide = LWH'(MAX_HEIGHT);
      w_eff = w_wide[CW-1:0];
      h_eff = h_wide[RW-1:0];
   end

   // Position counters: pixel column/row plus in-block offsets and block indexes
   logic [CW-1:0]    col_ff, col_in, col_a;
   logic [RW-1:0]    row_ff, row_in, row_a;
   logic [BW-1:0]    cm_ff, cm_in, cm_a, rm_ff, rm_in, rm_a;
   logic [IDX_W-1:0] bc_ff, bc_in, bc_a, br_ff, br_in, br_a;
   logic             last_a;

   always_comb begin
      col_a = col_ff; row_a = row_ff; cm_a = cm_ff; rm_a = rm_ff;
      bc_a = bc_ff;   br_a = br_ff;
      if (req_data.frame_start) begin
         col_a = '0; row_a = '0; cm_a = '0; rm_a = '0; bc_a = '0; br_a = '0;
      end
      // counter past a shrunken width
      if (col_a >= w_eff) begin
         col_a = '0; cm_a = '0; bc_a = '0;
         row_a = row_a + RW'(1);
         if (rm_a == EDGE_LAST) begin
            rm_a = '0;
            br_a = br_a + IDX_W'(1);
         end else begin
            rm_a = rm_a + BW'(1);
         end
      end
      if (row_a >= h_eff) begin
         row_a = '0; rm_a = '0; br_a = '0;
      end

      // bottom-right block of the frame: no further block fits right or below
      last_a = (({1'b0, col_a} + (CW+1)'(BLOCK_EDGE + 1)) > {1'b0, w_eff}) &&
               (({1'b0, row_a} + (RW+1)'(BLOCK_EDGE + 1)) > {1'b0, h_eff});

      // advance past this pixel
      col_in = col_a + CW'(1);
      cm_in  = (cm_a == EDGE_LAST) ? '0 : cm_a + BW'(1);
      bc_in  = (cm_a == EDGE_LAST) ? bc_a + IDX_W'(1) : bc_a;
      row_in = row_a; rm_in = rm_a; br_in = br_a;
      if (col_in >= w_eff) begin
         col_in = '0; cm_in = '0; bc_in = '0;
         row_in = row_a + RW'(1);
         if (rm_a == EDGE_LAST) begin
            rm_in = '0;
            br_in = br_a + IDX_W'(1);
         end else begin
            rm_in = rm_a + BW'(1);
         end
         if (row_in >= h_eff) begin
            row_in = '0; rm_in = '0; br_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; cm_ff <= '0; rm_ff <= '0;
         bc_ff <= '0;  br_ff <= '0;
      end else if (cmd.accept) begin
         col_ff <= col_in; row_ff <= row_in; cm_ff <= cm_in; rm_ff <= rm_in;
         bc_ff <= bc_in;   br_ff <= br_in;
      end
   end

   logic row_in_store, block_end;
   assign row_in_store = (rm_a != EDGE_LAST);
   assign block_end    = (rm_a == EDGE_LAST) && (cm_a == EDGE_LAST);

   // Line store for the upper rows of the block row
   logic [PW-1:0]  store [STORE_DEPTH];
   logic [PW-1:0]  rdata_ff;
   logic [AW:0]    wr_addr_wide, rd_addr_wide;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [CW-1:0]  base_ff;
   logic [BW-1:0]  fr_ff, fc_ff;

   always_comb begin
      wr_addr_wide = (AW+1)'(rm_a) * (AW+1)'(MAX_WIDTH) + (AW+1)'(col_a);
      rd_addr_wide = (AW+1)'(fr_ff) * (AW+1)'(MAX_WIDTH) + (AW+1)'(base_ff)
                     + (AW+1)'(fc_ff);
      wr_addr = wr_addr_wide[AW-1:0];
      rd_addr = rd_addr_wide[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && row_in_store) store[wr_addr] <= req_data.pixel_value;
      if (cmd.fetch_issue) rdata_ff <= store[rd_addr];
   end

   // Fetch walk over the upper rows of the block
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         base_ff <= col_a - CW'(BLOCK_EDGE - 1);
         fr_ff   <= '0;
         fc_ff   <= '0;
      end else if (cmd.fetch_issue) begin
         if (fc_ff == EDGE_LAST) begin
            fc_ff <= '0;
            fr_ff <= fr_ff + BW'(1);
         end else begin
            fc_ff <= fc_ff + BW'(1);
         end
      end
   end

   // First pixels of the bottom row of the current block
   logic [PW-1:0] partial_ff [BLOCK_EDGE-1];

   always_ff @(posedge clock) begin
      if (cmd.accept && !row_in_store && (cm_a != EDGE_LAST))
         partial_ff[cm_a] <= req_data.pixel_value;
   end

   // Block values: bottom row loaded on the last pixel, upper rows shifted in,
   // then sorted by odd-even transposition
   logic [PW-1:0] vals_ff [NPIX];
   logic [PW-1:0] vals_in [NPIX];

   always_comb begin
      for (int i = 0; i < NPIX; i++) vals_in[i] = vals_ff[i];
      if (cmd.accept) begin
         for (int c = 0; c < BLOCK_EDGE - 1; c++) vals_in[NFETCH + c] = partial_ff[c];
         vals_in[NPIX-1] = req_data.pixel_value;
      end else if (cmd.fetch_capture) begin
         for (int i = 0; i < NFETCH - 1; i++) vals_in[i] = vals_ff[i+1];
         vals_in[NFETCH-1] = rdata_ff;
      end else if (cmd.sort_step) begin
         for (int i = 0; i < NPIX - 1; i++) begin
            if ((((i & 1) == 1) == cmd.sort_odd) && (vals_ff[i] > vals_ff[i+1])) begin
               vals_in[i]   = vals_ff[i+1];
               vals_in[i+1] = vals_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NPIX; i++) vals_ff[i] <= vals_in[i];
   end

   // Block indexes held from the last pixel
   logic [IDX_W-1:0] bcol_ff, brow_ff;
   logic             last_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         bcol_ff <= bc_a;
         brow_ff <= br_a;
         last_ff <= last_a;
      end
   end

   // Median of the sorted values
   logic [PW:0]   mid_sum;
   logic [PW-1:0] median;

   always_comb begin
      if ((NPIX & 1) == 0) begin
         mid_sum = {1'b0, vals_ff[NPIX/2]} + {1'b0, vals_ff[NPIX/2 - 1]};
         median  = mid_sum[PW:1];
      end else begin
         mid_sum = {1'b0, vals_ff[NPIX/2]};
         median  = vals_ff[NPIX/2];
      end
   end

   // Output register
   logic             rsp_valid_ff;
   bmd_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.median_value <= median;
         rsp_data_ff.block_column <= bcol_ff;
         rsp_data_ff.block_row    <= brow_ff;
         rsp_data_ff.frame_last   <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.block_end = block_end;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

// File: rtl/bmd_controller.sv
// Controller: sequences accept, line store fetch, sort passes and result load.
module bmd_controller #(
   parameter int BLOCK_EDGE = bmd_pkg::DEF_BLOCK_EDGE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bmd_pkg::dp_status_type status,
   output bmd_pkg::ctrl_cmd_type  cmd
);

   localparam int NPIX   = BLOCK_EDGE * BLOCK_EDGE;
   localparam int NFETCH = (BLOCK_EDGE - 1) * BLOCK_EDGE;
   localparam int CNW    = $clog2(NPIX + 1);

   bmd_pkg::ctrl_state_type state_ff, state_in;
   logic [CNW-1:0]          cnt_ff, cnt_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmd_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         bmd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               if (status.block_end) state_in = bmd_pkg::ST_FETCH;
            end
         end
         bmd_pkg::ST_FETCH: begin
            // one read issued per beat, its data captured in the next beat
            cmd.fetch_issue   = (cnt_ff < CNW'(NFETCH));
            cmd.fetch_capture = (cnt_ff != '0);
            if (cnt_ff == CNW'(NFETCH)) begin
               cnt_in   = '0;
               state_in = bmd_pkg::ST_SORT;
            end else begin
               cnt_in = cnt_ff + CNW'(1);
            end
         end
         bmd_pkg::ST_SORT: begin
            cmd.sort_step = 1'b1;
            cmd.sort_odd  = cnt_ff[0];
            if (cnt_ff == CNW'(NPIX - 1)) begin
               cnt_in   = '0;
               state_in = bmd_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + CNW'(1);
            end
         end
         bmd_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = bmd_pkg::ST_IDLE;
            end
         end
         default: state_in = bmd_pkg::ST_IDLE;
      endcase
   end

endmodule
